@@ hw/rtl/vsp_pkg.sv @@
// Shared types and constants for the vertex sphere projection block.
package vsp_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int RADIUS_BITS    = 24;
    localparam int PROJ_BITS      = 25;
    localparam int OUT_DATA_BITS  = ((3 * PROJ_BITS + 7) / 8) * 8;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(65536);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_MUL,
        S_SQ_ACC,
        S_ROOT,
        S_SC_MUL,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/vertex_sphere_projection.sv @@
// Vertex sphere projection: scales a signed Q8.16 vertex onto a sphere of set radius.
// One vertex word goes through squaring of each axis on the shared multiplier,
// COORD_BITS root steps, then for each axis one multiply by the radius and 24
// restoring divide steps, all through one multiplier and one compare-subtract
// unit. A zero vector skips root and divides. The input side is ready only between
// vertices; a finished result sits in the output register so the next vertex can
// be taken while it waits. Results are truncated toward zero, with magnitude never
// above the radius.
module vertex_sphere_projection #(
    parameter int COORD_BITS = vsp_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration: sphere_radius, unsigned Q8.16
    input  logic                                   i_cfg_we,
    input  logic [vsp_pkg::RADIUS_BITS-1:0]        i_cfg_wdata,
    // input stream
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: coord_x, coord_y, coord_z (COORD_BITS each), zero padding
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      i_s_tdata,
    // output stream
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // tdata: proj_x, proj_y, proj_z (25 bits each), zero padding
    output logic [vsp_pkg::OUT_DATA_BITS-1:0]      o_m_tdata,
    // tuser: zero_length
    output logic [0:0]                             o_m_tuser
);
    import vsp_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int RB = RADIUS_BITS;
    localparam int MW = (N > RB) ? N : RB;
    localparam int PW = N + MW;
    localparam int SW = 2 * N;
    localparam int CW = $clog2(MW + 1);

    t_state r_state, n_state;

    logic [RB-1:0]  r_radius;
    logic [N-1:0]   r_mag [3];
    logic [2:0]     r_neg;
    logic [1:0]     r_idx;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  r_prod;
    logic [SW-1:0]  r_sum;
    logic [N+1:0]   r_rem;
    logic [N-1:0]   r_root;
    logic [RB-1:0]  r_dlow;
    logic [RB-1:0]  r_quo;
    logic [RB-1:0]  r_q [3];
    logic           r_zero;

    logic                     r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;
    logic                     r_out_zero;

    // control
    logic in_accept;
    logic out_free;
    logic out_load;

    // shared multiplier
    logic [N-1:0]  mul_a;
    logic [MW-1:0] mul_b;
    logic [PW-1:0] mul_p;

    // shared compare-subtract
    logic [N+1:0] cs_a;
    logic [N+1:0] cs_b;
    logic [N+1:0] cs_diff;
    logic         cs_ge;

    logic [SW-1:0] acc_sum;
    logic          last_axis;
    logic [OUT_DATA_BITS-1:0] proj_data;

    assign out_free  = !r_out_valid || i_m_tready;
    assign in_accept = i_s_tvalid && o_s_tready;
    assign last_axis = (r_idx == 2'd2);

    // multiplier: squares first, then magnitude times radius
    always_comb begin
        mul_a = r_mag[r_idx];
        if (r_state == S_SC_MUL) begin
            mul_b = MW'(r_radius);
        end else begin
            mul_b = MW'(r_mag[r_idx]);
        end
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    assign acc_sum = r_sum + r_prod[SW-1:0];

    // compare-subtract: root trial in S_ROOT, divisor trial in S_DIV
    always_comb begin
        if (r_state == S_DIV) begin
            cs_a = {1'b0, r_rem[N-1:0], r_dlow[RB-1]};
            cs_b = {2'b00, r_root};
        end else begin
            cs_a = {r_rem[N-1:0], r_sum[SW-1 -: 2]};
            cs_b = {r_root, 2'b01};
        end
        cs_ge   = (cs_a >= cs_b);
        cs_diff = cs_a - cs_b;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_SQ_MUL;
            end
            S_SQ_MUL: n_state = S_SQ_ACC;
            S_SQ_ACC: begin
                if (!last_axis) begin
                    n_state = S_SQ_MUL;
                end else if (acc_sum == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_cnt == CW'(N - 1)) n_state = S_SC_MUL;
            end
            S_SC_MUL:   n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CW'(RB - 1)) begin
                    n_state = last_axis ? S_DONE : S_SC_MUL;
                end
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            S_DONE:  out_load   = out_free;
            default: begin
                o_s_tready = 1'b0;
                out_load   = 1'b0;
            end
        endcase
    end

    // clamp to radius, zero a zero-length vector and restore sign for each axis
    always_comb begin
        logic [RB-1:0]        q;
        logic [PROJ_BITS-1:0] mag;
        proj_data = '0;
        for (int i = 0; i < 3; i++) begin
            q   = (r_q[i] > r_radius) ? r_radius : r_q[i];
            mag = r_zero ? '0 : {1'b0, q};
            proj_data[i*PROJ_BITS +: PROJ_BITS] = r_neg[i] ? (~mag + 1'b1) : mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_radius <= RADIUS_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_radius <= i_cfg_wdata;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic [N-1:0] f;
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        for (int i = 0; i < 3; i++) begin
                            f = i_s_tdata[i*N +: N];
                            r_neg[i] <= f[N-1];
                            r_mag[i] <= f[N-1] ? (~f + 1'b1) : f;
                        end
                        r_sum <= '0;
                        r_idx <= '0;
                    end
                end
                S_SQ_MUL: r_prod <= mul_p;
                S_SQ_ACC: begin
                    r_sum  <= acc_sum;
                    r_zero <= (acc_sum == '0);
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                    r_idx  <= last_axis ? 2'd0 : r_idx + 2'd1;
                end
                S_ROOT: begin
                    r_rem  <= cs_ge ? cs_diff : cs_a;
                    r_root <= {r_root[N-2:0], cs_ge};
                    r_sum  <= {r_sum[SW-3:0], 2'b00};
                    r_cnt  <= r_cnt + 1'b1;
                end
                S_SC_MUL: r_prod <= mul_p;
                S_DIV_INIT: begin
                    // upper part is below the length since magnitude <= length
                    r_rem  <= (N+2)'(r_prod[N+RB-1:RB]);
                    r_dlow <= r_prod[RB-1:0];
                    r_cnt  <= '0;
                end
                S_DIV: begin
                    r_rem  <= cs_ge ? cs_diff : cs_a;
                    r_dlow <= {r_dlow[RB-2:0], 1'b0};
                    r_quo  <= {r_quo[RB-2:0], cs_ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(RB - 1)) begin
                        r_q[r_idx] <= {r_quo[RB-2:0], cs_ge};
                        r_idx      <= r_idx + 2'd1;
                    end
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= proj_data;
            r_out_zero <= r_zero;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_zero;

`ifndef NO_ASSERTIONS
    a_zero_flag_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("zero_length word carries nonzero data");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_SQ_MUL))
        else $error("accepted vertex did not start squaring");

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_zero) |->
            (r_q[0] <= r_radius && r_q[1] <= r_radius && r_q[2] <= r_radius))
        else $error("quotient above radius");
`endif

endmodule

@@ tb/vertex_sphere_projection_test.sv @@
// Self-checking stream testbench for vertex_sphere_projection.
module vertex_sphere_projection_test;
    import vsp_pkg::*;

    localparam int COORD_W          = COORD_BITS_DEF;
    localparam int IN_DATA_BITS     = ((3 * COORD_W + 7) / 8) * 8;
    localparam int RUN_LIMIT        = 700000;
    localparam int RANDOM_PER_PHASE = 117;
    localparam int PHASES           = 8;

    localparam logic [COORD_W-1:0] C_ZERO    = '0;
    localparam logic [COORD_W-1:0] C_ONE     = COORD_W'(1);
    localparam logic [COORD_W-1:0] C_NEG_ONE = '1;
    localparam logic [COORD_W-1:0] C_MAX     = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic [COORD_W-1:0] C_MIN     = {1'b1, {(COORD_W - 1){1'b0}}};
    localparam logic [COORD_W-1:0] C_UNIT    = COORD_W'(65536);

    typedef struct packed {
        logic [PROJ_BITS-1:0] px;
        logic [PROJ_BITS-1:0] py;
        logic [PROJ_BITS-1:0] pz;
        logic                 zero_len;
    } t_projection;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [RADIUS_BITS-1:0]     i_cfg_wdata = '0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    logic [IN_DATA_BITS-1:0]    i_s_tdata = '0;
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]   o_m_tdata;
    logic [0:0]                 o_m_tuser;

    // no idling on either side while set
    logic steady = 1'b0;
    int   cycles = 0;

    class t_projection_scoreboard;
        logic [RADIUS_BITS-1:0] radius;
        t_projection            expected_points[$];
        int                     mismatches;

        function new();
            radius     = RADIUS_RESET;
            mismatches = 0;
        endfunction

        // floor(sqrt(s)), one result bit per step from the top
        function automatic longint unsigned floor_root(longint unsigned s);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int b = 26; b >= 0; b--) begin
                trial = r | (64'd1 << b);
                if (trial * trial <= s)
                    r = trial;
            end
            return r;
        endfunction

        function automatic longint unsigned magnitude(logic [COORD_W-1:0] c);
            longint unsigned m;
            m = 64'(c);
            if (c[COORD_W-1])
                m = (64'd1 << COORD_W) - m;
            return m;
        endfunction

        function automatic logic [PROJ_BITS-1:0] scale_axis(logic [COORD_W-1:0] c,
                                                              longint unsigned len);
            longint unsigned q;
            q = (magnitude(c) * 64'(radius)) / len;
            if (q > 64'(radius))
                q = 64'(radius);
            if (c[COORD_W-1])
                q = 64'd0 - q;
            return q[PROJ_BITS-1:0];
        endfunction

        function void note_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [COORD_W-1:0] z);
            t_projection     p;
            longint unsigned s;
            longint unsigned len;
            s = magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y)
                + magnitude(z) * magnitude(z);
            if (s == 0) begin
                p = '{px: '0, py: '0, pz: '0, zero_len: 1'b1};
            end else begin
                len = floor_root(s);
                p.px = scale_axis(x, len);
                p.py = scale_axis(y, len);
                p.pz = scale_axis(z, len);
                p.zero_len = 1'b0;
            end
            expected_points.push_back(p);
        endfunction

        task report_mismatch(string what, logic [PROJ_BITS-1:0] got,
                             logic [PROJ_BITS-1:0] wanted);
            mismatches++;
            $display("mismatch %s: got %h, wanted %h at %0t", what, got, wanted, $realtime);
        endtask

        task check_projection(logic [OUT_DATA_BITS-1:0] data, logic zero_len);
            t_projection w;
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected word", data[PROJ_BITS-1:0], '0);
            end else begin
                w = expected_points.pop_front();
                if (data[PROJ_BITS-1:0] !== w.px)
                    report_mismatch("proj_x", data[PROJ_BITS-1:0], w.px);
                if (data[2*PROJ_BITS-1:PROJ_BITS] !== w.py)
                    report_mismatch("proj_y", data[2*PROJ_BITS-1:PROJ_BITS], w.py);
                if (data[3*PROJ_BITS-1:2*PROJ_BITS] !== w.pz)
                    report_mismatch("proj_z", data[3*PROJ_BITS-1:2*PROJ_BITS], w.pz);
                if (zero_len !== w.zero_len)
                    report_mismatch("zero_length", PROJ_BITS'(zero_len),
                                    PROJ_BITS'(w.zero_len));
            end
        endtask
    endclass

    t_projection_scoreboard board = new();

    vertex_sphere_projection DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("vertex_sphere_projection_test failed");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge that accepts the word.
    task automatic send_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [COORD_W-1:0] z);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_DATA_BITS'({z, y, x});
        do @(posedge i_clk); while (!o_s_tready);
        board.note_vertex(x, y, z);
    endtask

    task automatic write_radius(logic [RADIUS_BITS-1:0] r);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.radius = r;
    endtask

    task automatic wait_drained();
        while (board.expected_points.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [COORD_W-1:0] random_coord(int kind);
        logic [COORD_W-1:0] v;
        int k;
        v = COORD_W'($urandom);
        if (kind == 5 || kind == 6) begin
            k = $urandom_range(0, 12);
            v = COORD_W'($urandom_range(0, 1 << k));
            if ($urandom_range(0, 1)) v = -v;
        end else if (kind == 8) begin
            case ($urandom_range(0, 4))
                0: v = C_MAX;
                1: v = C_MIN;
                2: v = C_ONE;
                3: v = C_NEG_ONE;
                default: v = C_ZERO;
            endcase
        end else if (kind == 9) begin
            v = COORD_W'($urandom_range(0, 32'h1FFFF));
            if ($urandom_range(0, 1)) v = -v;
        end
        return v;
    endfunction

    task automatic send_random_vertex();
        int kind;
        logic [COORD_W-1:0] x, y, z;
        kind = $urandom_range(0, 9);
        x = random_coord(kind);
        y = random_coord(kind);
        z = random_coord(kind);
        if (kind == 0) begin
            x = C_ZERO; y = C_ZERO; z = C_ZERO;
        end else if (kind == 7) begin
            // single nonzero axis
            case ($urandom_range(0, 2))
                0: begin y = C_ZERO; z = C_ZERO; end
                1: begin x = C_ZERO; z = C_ZERO; end
                default: begin x = C_ZERO; y = C_ZERO; end
            endcase
        end
        send_vertex(x, y, z);
    endtask

    // receive side
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            board.check_projection(o_m_tdata, o_m_tuser[0]);
        end
    end

    // stimulus
    initial begin
        logic [RADIUS_BITS-1:0] radii[PHASES];
        radii[0] = RADIUS_RESET;
        radii[1] = '1;
        radii[2] = '0;
        radii[3] = RADIUS_BITS'(1);
        radii[4] = RADIUS_BITS'($urandom);
        radii[5] = RADIUS_BITS'(24'h7FFFFF);
        radii[6] = RADIUS_BITS'($urandom_range(1, 24'h3FFFF));
        radii[7] = RADIUS_BITS'(24'h010000);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero vector, axis extremes, unit, small and mixed-sign vectors
        send_vertex(C_ZERO, C_ZERO, C_ZERO);
        send_vertex(C_MAX, C_ZERO, C_ZERO);
        send_vertex(C_ZERO, C_MAX, C_ZERO);
        send_vertex(C_ZERO, C_ZERO, C_MAX);
        send_vertex(C_MIN, C_ZERO, C_ZERO);
        send_vertex(C_ZERO, C_MIN, C_ZERO);
        send_vertex(C_ZERO, C_ZERO, C_MIN);
        send_vertex(C_MAX, C_MAX, C_MAX);
        send_vertex(C_MIN, C_MIN, C_MIN);
        send_vertex(C_MAX, C_MIN, C_MAX);
        send_vertex(C_ONE, C_ZERO, C_ZERO);
        send_vertex(C_NEG_ONE, C_ZERO, C_ZERO);
        send_vertex(C_ONE, C_ONE, C_ONE);
        send_vertex(C_NEG_ONE, C_NEG_ONE, C_NEG_ONE);
        send_vertex(C_UNIT, C_ZERO, C_ZERO);
        send_vertex(COORD_W'(3), COORD_W'(4), C_ZERO);
        send_vertex(C_MIN, C_MAX, C_ONE);
        send_vertex(C_ONE, C_MIN, C_NEG_ONE);
        send_vertex(C_ZERO, C_ZERO, C_ZERO);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                i_s_tvalid <= 1'b0;
                wait_drained();
                @(posedge i_clk);
                write_radius(radii[ph]);
                send_vertex(C_ZERO, C_ZERO, C_ZERO);
                send_vertex(C_MIN, C_MAX, C_MIN);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (i % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send_random_vertex();
            end
        end
        i_s_tvalid <= 1'b0;
        steady = 1'b0;

        wait_drained();
        repeat (120) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_points.size() == 0)
            $display("vertex_sphere_projection_test passed");
        else
            $display("vertex_sphere_projection_test failed");
        $finish;
    end

endmodule

@@ vertex_sphere_projection.f @@
hw/rtl/vsp_pkg.sv
hw/rtl/vertex_sphere_projection.sv
tb/vertex_sphere_projection_test.sv
